### sv/dclc_pkg.sv
// Shared types and codes for the door code lock controller.
package dclc_pkg;

  // Request kinds carried on the input tuser.
  typedef enum logic [2:0] {
    CMD_KEY     = 3'd0,
    CMD_START   = 3'd1,
    CMD_INSIDE  = 3'd2,
    CMD_OUTSIDE = 3'd3,
    CMD_TICK    = 3'd4
  } cmd_e;

  // Event codes carried on the output tuser.
  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_DIGIT     = 3'd1,
    EV_GRANTED   = 3'd2,
    EV_RETRY     = 3'd3,
    EV_DENIED    = 3'd4,
    EV_CLOSED    = 3'd5,
    EV_OPENED_IN = 3'd6,
    EV_ALARM_END = 3'd7
  } event_e;

  // Register indexes (byte address is 4 * index).
  localparam logic [1:0] REG_CODE_BCD   = 2'd0;
  localparam logic [1:0] REG_MAX_TRIES  = 2'd1;
  localparam logic [1:0] REG_DOOR_TICKS = 2'd2;
  localparam logic [1:0] REG_ALARM_TICKS = 2'd3;

  localparam logic [15:0] CODE_BCD_RST    = 16'd0;
  localparam logic [3:0]  MAX_TRIES_RST   = 4'd3;
  localparam logic [15:0] DOOR_TICKS_RST  = 16'd19531;
  localparam logic [15:0] ALARM_TICKS_RST = 16'd11719;

  localparam logic [7:0] OCC_MAX   = 8'd255;
  localparam logic [3:0] TRIES_MAX = 4'd15;

  // One result as held in the output register.
  typedef struct packed {
    event_e     ev;
    logic       entry_open;
    logic       buzzer;
    logic       count_changed;
    logic [7:0] occupants;
    logic       door_is_open;
  } result_t;

endpackage

### sv/door_code_lock_controller_top.sv
// Door code lock controller: code entry, door, occupant count and shared timer.
// Usage:
//   Input stream (s_axis_*): one request per accepted beat. tuser carries the
//   request kind (key digit, start entry, inside button, outside close, tick);
//   tdata carries the keypad value, used for key digits only.
//   Output stream (m_axis_*): exactly one result per request, in order. tdata
//   holds door position, occupant count, count-changed flag, buzzer and entry
//   flag; tuser holds the event code of that request.
//   Configuration (APB): code, retry limit, door-open and alarm tick counts at
//   byte addresses 0, 4, 8 and 12. Write only while no request is in flight.
// Timing and throughput:
//   The result of a request is registered and presented in the cycle after it is
//   accepted. One request per cycle is sustained while the receiver keeps up; the
//   state update is a single pass of short logic between the state registers and the output register.
// Stall behavior:
//   The output register holds its result while m_axis_tready is low. A new
//   request is still accepted in the cycle the held result is taken, so the
//   input stalls only while a result waits and the receiver is not ready.
// Reset: rst_ni clears all control state and restores the register defaults:
//   door closed, nobody inside, no entry, no alarm, no timer running.
module door_code_lock_controller_top
  import dclc_pkg::*;
#(
  parameter int CODE_DIGITS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [3:0] key, [7:4] zero
  input  logic [2:0]  s_axis_tuser,   // [2:0] cmd
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [0] door_is_open, [8:1] occupants,
                                      // [9] count_changed, [10] buzzer,
                                      // [11] entry_open, [15:12] zero
  output logic [2:0]  m_axis_tuser,   // [2:0] event_res
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IdxW  = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
  localparam int Slots = 2 ** IdxW;
  localparam logic [IdxW:0] LastIdx = (IdxW + 1)'(CODE_DIGITS);

  // Configuration registers
  logic [15:0] code_bcd_q;
  logic [3:0]  max_tries_q;
  logic [15:0] door_ticks_q;
  logic [15:0] alarm_ticks_q;

  // Controller state
  logic            door_q, door_d;
  logic [7:0]      occ_q, occ_d;
  logic            entering_q, entering_d;
  logic [IdxW-1:0] digit_q, digit_d;
  logic            mismatch_q, mismatch_d;
  logic [3:0]      tries_q, tries_d;
  logic            alarm_q, alarm_d;
  logic            tmr_run_q, tmr_run_d;
  logic            tmr_alarm_q, tmr_alarm_d;
  logic [15:0]     tick_q, tick_d;

  // Output register
  logic    m_valid_q;
  result_t res_q, res_d;

  logic       s_fire;
  logic       cfg_wr;
  cmd_e       cmd;
  logic [3:0] key;

  // Expected digit per code position; positions above nibble 3 read as zero.
  logic [3:0] code_dig [Slots];

  for (genvar gi = 0; gi < Slots; gi++) begin : g_dig
    if (gi < CODE_DIGITS && (CODE_DIGITS - 1 - gi) <= 3) begin : g_used
      assign code_dig[gi] = code_bcd_q[4*(CODE_DIGITS-1-gi) +: 4];
    end else begin : g_zero
      assign code_dig[gi] = 4'd0;
    end
  end

  assign cmd    = cmd_e'(s_axis_tuser);
  assign key    = s_axis_tdata[3:0];
  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign s_fire = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------
  // Configuration port: writes land in the access phase, reads are direct.
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_bcd_q    <= CODE_BCD_RST;
      max_tries_q   <= MAX_TRIES_RST;
      door_ticks_q  <= DOOR_TICKS_RST;
      alarm_ticks_q <= ALARM_TICKS_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_CODE_BCD:    code_bcd_q    <= pwdata[15:0];
        REG_MAX_TRIES:   max_tries_q   <= pwdata[3:0];
        REG_DOOR_TICKS:  door_ticks_q  <= pwdata[15:0];
        REG_ALARM_TICKS: alarm_ticks_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CODE_BCD:    prdata = {16'd0, code_bcd_q};
      REG_MAX_TRIES:   prdata = {28'd0, max_tries_q};
      REG_DOOR_TICKS:  prdata = {16'd0, door_ticks_q};
      REG_ALARM_TICKS: prdata = {16'd0, alarm_ticks_q};
      default:         prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Next state for one request.
  // ---------------------------------------------------------------------
  logic [IdxW:0] idx_inc;
  logic          tries_cap;
  logic [3:0]    tries_inc;
  logic [15:0]   tick_inc;
  logic [15:0]   tick_limit;
  logic          changed;
  event_e        ev;

  assign idx_inc    = {1'b0, digit_q} + 1'b1;
  assign tries_cap  = (tries_q < TRIES_MAX);
  assign tries_inc  = tries_cap ? tries_q + 4'd1 : tries_q;
  assign tick_inc   = tick_q + 16'd1;
  assign tick_limit = tmr_alarm_q ? alarm_ticks_q : door_ticks_q;

  always_comb begin
    door_d      = door_q;
    occ_d       = occ_q;
    entering_d  = entering_q;
    digit_d     = digit_q;
    mismatch_d  = mismatch_q;
    tries_d     = tries_q;
    alarm_d     = alarm_q;
    tmr_run_d   = tmr_run_q;
    tmr_alarm_d = tmr_alarm_q;
    tick_d      = tick_q;
    changed     = 1'b0;
    ev          = EV_NONE;

    unique case (cmd)
      CMD_KEY: begin
        if (entering_q) begin
          ev = EV_DIGIT;
          if (idx_inc >= LastIdx) begin
            // Full code entered: judge it, including the final digit.
            digit_d = '0;
            if (!mismatch_q && key == code_dig[digit_q]) begin
              entering_d  = 1'b0;
              door_d      = 1'b1;
              if (occ_q != OCC_MAX) begin
                occ_d   = occ_q + 8'd1;
                changed = 1'b1;
              end
              alarm_d     = 1'b0;
              tries_d     = '0;
              mismatch_d  = 1'b0;
              tmr_run_d   = 1'b1;
              tmr_alarm_d = 1'b0;
              tick_d      = '0;
              ev          = EV_GRANTED;
            end else begin
              mismatch_d = 1'b0;
              tries_d    = tries_inc;
              if (tries_inc >= max_tries_q) begin
                entering_d  = 1'b0;
                alarm_d     = 1'b1;
                tmr_run_d   = 1'b1;
                tmr_alarm_d = 1'b1;
                tick_d      = '0;
                ev          = EV_DENIED;
              end else begin
                ev = EV_RETRY;
              end
            end
          end else begin
            digit_d = idx_inc[IdxW-1:0];
            if (key != code_dig[digit_q]) begin
              mismatch_d = 1'b1;
            end
          end
        end
      end
      CMD_START: begin
        if (!entering_q) begin
          entering_d = 1'b1;
          digit_d    = '0;
          mismatch_d = 1'b0;
          tries_d    = '0;
        end
      end
      CMD_INSIDE: begin
        if (!entering_q && occ_q != 8'd0) begin
          if (door_q) begin
            door_d = 1'b0;
            ev     = EV_CLOSED;
          end else begin
            door_d      = 1'b1;
            occ_d       = occ_q - 8'd1;
            changed     = 1'b1;
            tmr_run_d   = 1'b1;
            tmr_alarm_d = 1'b0;
            tick_d      = '0;
            ev          = EV_OPENED_IN;
          end
        end
      end
      CMD_OUTSIDE: begin
        if (!entering_q) begin
          door_d = 1'b0;
          ev     = EV_CLOSED;
        end
      end
      CMD_TICK: begin
        if (!entering_q && tmr_run_q) begin
          tick_d = tick_inc;
          if (tick_inc >= tick_limit) begin
            tmr_run_d = 1'b0;
            tick_d    = '0;
            if (tmr_alarm_q) begin
              alarm_d = 1'b0;
              ev      = EV_ALARM_END;
            end else if (door_q) begin
              door_d = 1'b0;
              ev     = EV_CLOSED;
            end
          end
        end
      end
      default: ;
    endcase

    res_d.door_is_open  = door_d;
    res_d.occupants     = occ_d;
    res_d.count_changed = changed;
    res_d.buzzer        = alarm_d;
    res_d.entry_open    = entering_d;
    res_d.ev            = ev;
  end

  // Advance the state on every accepted request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      door_q      <= 1'b0;
      occ_q       <= '0;
      entering_q  <= 1'b0;
      digit_q     <= '0;
      mismatch_q  <= 1'b0;
      tries_q     <= '0;
      alarm_q     <= 1'b0;
      tmr_run_q   <= 1'b0;
      tmr_alarm_q <= 1'b0;
      tick_q      <= '0;
    end else if (s_fire) begin
      door_q      <= door_d;
      occ_q       <= occ_d;
      entering_q  <= entering_d;
      digit_q     <= digit_d;
      mismatch_q  <= mismatch_d;
      tries_q     <= tries_d;
      alarm_q     <= alarm_d;
      tmr_run_q   <= tmr_run_d;
      tmr_alarm_q <= tmr_alarm_d;
      tick_q      <= tick_d;
    end
  end

  // Output register: load on accept, drop once taken, hold while stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (s_fire) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'd0, res_q.entry_open, res_q.buzzer, res_q.count_changed,
                          res_q.occupants, res_q.door_is_open};
  assign m_axis_tuser  = res_q.ev;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !entering_q |-> (digit_q == '0 && !mismatch_q))
    else $error("digit index or mismatch left set outside entry");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, digit_q} < LastIdx)
    else $error("digit index beyond code length");

  a_granted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && res_q.ev == EV_GRANTED) |->
      (res_q.door_is_open && !res_q.buzzer && !res_q.entry_open))
    else $error("grant result without open door and silent buzzer");

  a_denied: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && res_d.ev == EV_DENIED) |=> (alarm_q && tmr_run_q && tmr_alarm_q))
    else $error("denial did not start the alarm timing");

endmodule

### sim/door_code_lock_controller_top_test.sv
// Self-checking testbench for the door code lock controller: streams, APB setup, prediction.
module door_code_lock_controller_top_test
  import dclc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Match the default digit count of the block.
  localparam int DIGITS = 4;
  // Long receiver hold-off, long enough to back the block up into its input.
  localparam int HOLD_CYCLES = 300;
  // Stop printing detail after this many mismatches; keep counting.
  localparam int PRINT_LIMIT = 40;

  typedef struct packed {
    logic [2:0] cmd;
    logic [3:0] key;
  } lock_req_t;

  // Clock, reset and block ports; every input has a known value from time zero.
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;    // [3:0] key, [7:4] zero
  logic [2:0]  s_axis_tuser = '0;    // [2:0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [0] door, [8:1] occupants, [9] changed,
                                     // [10] buzzer, [11] entry, [15:12] zero
  logic [2:0]  m_axis_tuser;         // [2:0] event code
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Requests waiting to be sent and status words waiting to come back.
  lock_req_t pending_reqs[$];
  result_t   expected_status[$];

  // Predicted configuration.
  logic [15:0] m_code;
  logic [3:0]  m_max_tries;
  logic [15:0] m_door_ticks;
  logic [15:0] m_alarm_ticks;

  // Predicted lock state.
  logic        m_door;
  logic [7:0]  m_occ;
  logic        m_entering;
  logic [3:0]  m_digit;
  logic        m_mismatch;
  logic [3:0]  m_tries;
  logic        m_alarm;
  logic        m_tmr_run;
  logic        m_tmr_alarm;
  logic [15:0] m_tmr_count;

  // Pacing controls, set by the sequencer between phases.
  bit src_idle = 1'b0;
  bit sink_idle = 1'b0;
  int src_gap = 0;
  int sink_wait = 0;
  int sink_draw = 0;
  int hold_requests = 0;
  int holds_done = 0;
  int hold_left = 0;

  // Run statistics.
  int errors = 0;
  int reqs_queued = 0;
  int reqs_taken = 0;
  int results_seen = 0;
  int phases = 0;
  int grants = 0;
  int denials = 0;
  int retries = 0;
  int alarm_ends = 0;
  int closes = 0;
  int inside_opens = 0;
  int full_house = 0;

  lock_req_t drv_next;
  result_t   drv_want;
  result_t   mon_want;

  door_code_lock_controller_top #(
    .CODE_DIGITS(DIGITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // 20 ns clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Count one mismatch and print it while the log is still short.
  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= PRINT_LIMIT)
      $display("MISMATCH at result %0d, %s: got %0d, want %0d", results_seen, what, got,
               want);
  endtask

  // ---------------------------------------------------------------------------
  // Lock prediction
  // ---------------------------------------------------------------------------

  task automatic reset_lock_model();
    m_code        = CODE_BCD_RST;
    m_max_tries   = MAX_TRIES_RST;
    m_door_ticks  = DOOR_TICKS_RST;
    m_alarm_ticks = ALARM_TICKS_RST;
    m_door        = 1'b0;
    m_occ         = '0;
    m_entering    = 1'b0;
    m_digit       = '0;
    m_mismatch    = 1'b0;
    m_tries       = '0;
    m_alarm       = 1'b0;
    m_tmr_run     = 1'b0;
    m_tmr_alarm   = 1'b0;
    m_tmr_count   = '0;
  endtask

  // Digit the code expects at entry position idx; positions past the register read as 0.
  function automatic logic [3:0] code_digit(input int idx);
    int pos;
    if (idx >= DIGITS) return 4'd0;
    pos = DIGITS - 1 - idx;
    if (pos > 3) return 4'd0;
    return m_code[pos*4 +: 4];
  endfunction

  task automatic arm_timer(input logic for_alarm);
    m_tmr_run   = 1'b1;
    m_tmr_alarm = for_alarm;
    m_tmr_count = '0;
  endtask

  // Advance the predicted lock by one request and return its status word.
  task automatic step_lock(input logic [2:0] cmd, input logic [3:0] key,
                           output result_t res);
    logic        changed;
    event_e      ev;
    logic [15:0] limit;
    changed = 1'b0;
    ev      = EV_NONE;
    case (cmd)
      CMD_KEY: begin
        if (m_entering) begin
          if (key != code_digit(int'(m_digit))) m_mismatch = 1'b1;
          m_digit = m_digit + 4'd1;
          ev = EV_DIGIT;
          if (int'(m_digit) >= DIGITS) begin
            m_digit = '0;
            if (!m_mismatch) begin
              m_entering = 1'b0;
              m_door     = 1'b1;
              if (m_occ != OCC_MAX) begin
                m_occ   = m_occ + 8'd1;
                changed = 1'b1;
              end
              m_alarm = 1'b0;
              m_tries = '0;
              arm_timer(1'b0);
              ev = EV_GRANTED;
            end else begin
              m_mismatch = 1'b0;
              if (m_tries != TRIES_MAX) m_tries = m_tries + 4'd1;
              if (m_tries >= m_max_tries) begin
                m_entering = 1'b0;
                m_alarm    = 1'b1;
                arm_timer(1'b1);
                ev = EV_DENIED;
              end else begin
                ev = EV_RETRY;
              end
            end
          end
        end
      end
      CMD_START: begin
        if (!m_entering) begin
          m_entering = 1'b1;
          m_digit    = '0;
          m_mismatch = 1'b0;
          m_tries    = '0;
        end
      end
      CMD_INSIDE: begin
        if (!m_entering && m_occ != 0) begin
          if (m_door) begin
            m_door = 1'b0;
            ev = EV_CLOSED;
          end else begin
            m_door  = 1'b1;
            m_occ   = m_occ - 8'd1;
            changed = 1'b1;
            arm_timer(1'b0);
            ev = EV_OPENED_IN;
          end
        end
      end
      CMD_OUTSIDE: begin
        if (!m_entering) begin
          m_door = 1'b0;
          ev = EV_CLOSED;
        end
      end
      CMD_TICK: begin
        if (!m_entering && m_tmr_run) begin
          limit = m_tmr_alarm ? m_alarm_ticks : m_door_ticks;
          m_tmr_count = m_tmr_count + 16'd1;
          if (m_tmr_count >= limit) begin
            m_tmr_run   = 1'b0;
            m_tmr_count = '0;
            if (m_tmr_alarm) begin
              m_alarm = 1'b0;
              ev = EV_ALARM_END;
            end else if (m_door) begin
              m_door = 1'b0;
              ev = EV_CLOSED;
            end
          end
        end
      end
      default: ;  // unused kinds are ignored
    endcase
    res.ev            = ev;
    res.entry_open    = m_entering;
    res.buzzer        = m_alarm;
    res.count_changed = changed;
    res.occupants     = m_occ;
    res.door_is_open  = m_door;
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: send queued requests, predict each one as it is accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
      src_gap       <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        step_lock(s_axis_tuser, s_axis_tdata[3:0], drv_want);
        expected_status.push_back(drv_want);
        reqs_taken++;
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // Hold the request until the block takes it.
      end else if (src_gap != 0) begin
        s_axis_tvalid <= 1'b0;
        src_gap       <= src_gap - 1;
      end else if (pending_reqs.size() != 0) begin
        drv_next = pending_reqs.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= drv_next.cmd;
        s_axis_tdata  <= {4'b0000, drv_next.key};
        src_gap       <= src_idle ? int'($urandom_range(0, 19)) : 0;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Long hold-off of the receiver, counted here on request of the sequencer.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left  <= 0;
      holds_done <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_done != hold_requests) begin
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  // Compare one accepted status word with the oldest prediction.
  task automatic check_status();
    results_seen++;
    if (expected_status.size() == 0) begin
      report_mismatch("status with no request pending", m_axis_tdata, 0);
      return;
    end
    mon_want = expected_status.pop_front();
    if (m_axis_tdata[0] !== mon_want.door_is_open)
      report_mismatch("door_is_open", m_axis_tdata[0], mon_want.door_is_open);
    if (m_axis_tdata[8:1] !== mon_want.occupants)
      report_mismatch("occupants", m_axis_tdata[8:1], mon_want.occupants);
    if (m_axis_tdata[9] !== mon_want.count_changed)
      report_mismatch("count_changed", m_axis_tdata[9], mon_want.count_changed);
    if (m_axis_tdata[10] !== mon_want.buzzer)
      report_mismatch("buzzer", m_axis_tdata[10], mon_want.buzzer);
    if (m_axis_tdata[11] !== mon_want.entry_open)
      report_mismatch("entry_open", m_axis_tdata[11], mon_want.entry_open);
    if (m_axis_tuser !== mon_want.ev)
      report_mismatch("event_res", m_axis_tuser, mon_want.ev);
    case (mon_want.ev)
      EV_GRANTED:   grants++;
      EV_DENIED:    denials++;
      EV_RETRY:     retries++;
      EV_ALARM_END: alarm_ends++;
      EV_CLOSED:    closes++;
      EV_OPENED_IN: inside_opens++;
      default: ;
    endcase
    if (mon_want.occupants == OCC_MAX) full_house++;
  endtask

  // ---------------------------------------------------------------------------
  // Result monitor: check each accepted status word, pace tready.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_wait     <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_status();
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
      end else if (m_axis_tvalid && m_axis_tready) begin
        sink_draw = sink_idle ? int'($urandom_range(0, 19)) : 0;
        if (sink_draw != 0) begin
          m_axis_tready <= 1'b0;
          sink_wait     <= sink_draw - 1;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end else if (sink_wait != 0) begin
        m_axis_tready <= 1'b0;
        sink_wait     <= sink_wait - 1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration access
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] reg_mask(input logic [1:0] idx);
    case (idx)
      REG_MAX_TRIES: return 32'h0000_000F;
      default:       return 32'h0000_FFFF;
    endcase
  endfunction

  // Write one register, mirror it in the prediction, then read it back.
  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_CODE_BCD:    m_code        = val[15:0];
      REG_MAX_TRIES:   m_max_tries   = val[3:0];
      REG_DOOR_TICKS:  m_door_ticks  = val[15:0];
      REG_ALARM_TICKS: m_alarm_ticks = val[15:0];
      default: ;
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if ((prdata & reg_mask(idx)) !== (val & reg_mask(idx)))
      report_mismatch($sformatf("readback of register %0d", idx), prdata, val);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input logic [15:0] code, input logic [3:0] tries,
                            input logic [15:0] door_ticks, input logic [15:0] alarm_ticks);
    apb_write(REG_CODE_BCD, {16'h0, code});
    apb_write(REG_MAX_TRIES, {28'h0, tries});
    apb_write(REG_DOOR_TICKS, {16'h0, door_ticks});
    apb_write(REG_ALARM_TICKS, {16'h0, alarm_ticks});
    phases++;
  endtask

  // Wait until every queued request has been accepted and answered, then let the block settle.
  task automatic drain();
    while (reqs_taken != reqs_queued || expected_status.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  task automatic queue_req(input logic [2:0] cmd, input logic [3:0] key);
    lock_req_t r;
    r.cmd = cmd;
    r.key = key;
    pending_reqs.push_back(r);
    reqs_queued++;
  endtask

  function automatic logic [15:0] random_bcd();
    return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
            4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
  endfunction

  // Start entry and key the right code; now and then slip in a request the entry ignores.
  task automatic queue_grant();
    queue_req(CMD_START, 4'($urandom()));
    for (int i = 0; i < DIGITS; i++) begin
      if ($urandom_range(0, 9) == 0) queue_req(3'($urandom_range(1, 7)), 4'($urandom()));
      queue_req(CMD_KEY, code_digit(i));
    end
  endtask

  // Start entry and key several attempts with one bad digit each; maybe end on the right code.
  task automatic queue_bad_entry();
    int  tries;
    int  bad;
    bit  last_good;
    logic [3:0] k;
    tries     = $urandom_range(1, int'(m_max_tries) + 1);
    last_good = ($urandom_range(0, 3) == 0);
    queue_req(CMD_START, 4'($urandom()));
    for (int a = 0; a < tries; a++) begin
      bad = $urandom_range(0, DIGITS - 1);
      for (int i = 0; i < DIGITS; i++) begin
        k = code_digit(i);
        if (i == bad && !(last_good && a == tries - 1)) k = k ^ 4'($urandom_range(1, 15));
        queue_req(CMD_KEY, k);
      end
    end
  endtask

  // Mostly well-formed entries, with ticks, buttons, stray digits and noise around them.
  task automatic fill_traffic(input int n);
    int r;
    while (pending_reqs.size() < n) begin
      r = $urandom_range(0, 99);
      if (r < 35) queue_grant();
      else if (r < 55) queue_bad_entry();
      else if (r < 70) repeat ($urandom_range(1, 8)) queue_req(CMD_TICK, 4'($urandom()));
      else if (r < 80) repeat ($urandom_range(1, 2)) queue_req(CMD_INSIDE, 4'($urandom()));
      else if (r < 87) queue_req(CMD_OUTSIDE, 4'($urandom()));
      else if (r < 94) queue_req(CMD_KEY, 4'($urandom()));
      else repeat ($urandom_range(1, 3)) queue_req(3'($urandom()), 4'($urandom()));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  initial begin
    reset_lock_model();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Defaults after reset: idle requests first, then an all-zero code opens the door.
    queue_req(CMD_TICK, 4'h0);       // no timer running
    queue_req(CMD_INSIDE, 4'hF);     // nobody inside
    queue_req(CMD_OUTSIDE, 4'h0);
    queue_req(CMD_KEY, 4'h5);        // digit outside entry
    queue_req(3'd5, 4'hA);           // unused kinds
    queue_req(3'd6, 4'h5);
    queue_req(3'd7, 4'hF);
    queue_req(CMD_START, 4'h0);
    queue_req(CMD_START, 4'h3);      // start during entry
    repeat (DIGITS) queue_req(CMD_KEY, 4'h0);
    drain();

    // Non-decimal nibbles, one try, short timers.
    set_config(16'h9F37, 4'd1, 16'd1, 16'd2);
    queue_req(CMD_START, 4'h0);
    queue_req(CMD_INSIDE, 4'h0);     // buttons and ticks ignored during entry
    queue_req(CMD_TICK, 4'h0);
    queue_req(CMD_KEY, 4'h9);
    queue_req(CMD_KEY, 4'hF);
    queue_req(CMD_KEY, 4'h3);
    queue_req(CMD_KEY, 4'h7);        // granted, second occupant
    queue_req(CMD_TICK, 4'h0);       // auto-close on the first tick
    queue_req(CMD_START, 4'h0);
    repeat (DIGITS) queue_req(CMD_KEY, 4'h1);  // denied at once
    queue_req(CMD_INSIDE, 4'h0);     // opening from inside replaces the alarm timing
    queue_req(CMD_TICK, 4'h0);       // door closes, buzzer stays on
    drain();

    // No tries allowed and zero-length timers.
    set_config(16'h0000, 4'd0, 16'd0, 16'd0);
    queue_req(CMD_START, 4'h0);
    queue_req(CMD_KEY, 4'h8);
    repeat (DIGITS - 1) queue_req(CMD_KEY, 4'h0);
    queue_req(CMD_TICK, 4'h0);       // alarm ends on the first tick
    drain();

    // Random traffic, both sides idling.
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    set_config(random_bcd(), 4'd3, 16'd4, 16'd3);
    fill_traffic(200);
    drain();

    // Widest settings, sender at full rate.
    src_idle = 1'b0;
    set_config(16'hFFFF, 4'd15, 16'hFFFF, 16'hFFFF);
    fill_traffic(150);
    drain();

    // Back-pressure: the receiver holds off while the sender keeps offering.
    sink_idle = 1'b0;
    set_config(16'($urandom()), 4'd2, 16'd2, 16'd5);
    fill_traffic(120);
    hold_requests++;
    drain();

    // Pile up occupants with runs of grants, a tick now and then.
    src_idle  = 1'b1;
    sink_idle = 1'b0;
    set_config(random_bcd(), 4'($urandom_range(1, 15)), 16'd3, 16'd2);
    repeat (80) begin
      queue_grant();
      if ($urandom_range(0, 7) == 0) queue_req(CMD_TICK, 4'($urandom()));
    end
    drain();

    // Zero code, single try, one-tick timers.
    sink_idle = 1'b1;
    set_config(16'h0000, 4'd1, 16'd1, 16'd1);
    fill_traffic(100);
    drain();

    // Random settings to close.
    set_config(16'($urandom()), 4'($urandom()), 16'($urandom_range(1, 6)),
               16'($urandom_range(1, 6)));
    fill_traffic(100);
    drain();

    $display("Ran %0d requests over %0d register settings: %0d grants, %0d retries, %0d denials",
             reqs_taken, phases, grants, retries, denials);
    $display("Saw %0d alarm ends, %0d closes, %0d inside openings, %0d results at full room",
             alarm_ends, closes, inside_opens, full_house);
    if (errors == 0 && expected_status.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Give up if the run hangs.
  initial begin
    #15_000_000;
    $display("Timeout with %0d results outstanding", expected_status.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
